FILE: hdl/lpss_pkg.sv
// Shared types and constants for the LED panel scan sequencer.
`default_nettype none

package lpss_pkg;

	// Longest chain row and number of row address lines on the panel.
	localparam int MAX_LINE_WIDTH = 2048;
	localparam int ADDRESS_LINES  = 5;

	// Field widths fixed by the panel interface.
	localparam int PIX_W    = 32;
	localparam int ROW_W    = 5;
	localparam int HR_W     = 6;
	localparam int LW_CFG_W = 12;
	localparam int PC_W     = 7;
	localparam int PLANE_W  = 6;

	// Column counter and the width used to compare it against the row length.
	localparam int COL_W = $clog2(MAX_LINE_WIDTH);
	localparam int CMP_W = (COL_W + 1 > LW_CFG_W) ? COL_W + 1 : LW_CFG_W;

	localparam logic [ROW_W-1:0] ADDR_MASK = ROW_W'((1 << ADDRESS_LINES) - 1);

	localparam logic [HR_W-1:0]  HR_MAX = HR_W'(32);
	localparam logic [PC_W-1:0]  PC_MAX = PC_W'(64);
	localparam logic [CMP_W-1:0] LW_MAX = CMP_W'(MAX_LINE_WIDTH);

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LW_CFG_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_ROWS     = 2'd0,
		CFG_LINE_WIDTH    = 2'd1,
		CFG_PLANE_COUNT   = 2'd2,
		CFG_JITTER_ENABLE = 2'd3
	} cfg_index_t;

	// Register values after range limiting, as used by the scan logic.
	typedef struct packed {
		logic [HR_W-1:0]  half_rows;
		logic [CMP_W-1:0] line_width;
		logic [PC_W-1:0]  plane_count;
		logic             jitter_enable;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_bits;
		logic             oe_jitter;
		logic             buffer_request;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0]   rgb_bits;
		logic [ROW_W-1:0]   row_address;
		logic               blank;
		logic               clock_rise;
		logic               latch;
		logic [PLANE_W-1:0] bit_plane;
		logic               active_buffer;
		logic               last;
	} out_item_t;

	// One decoded pixel held between the scan counters and the output sequencer.
	typedef struct packed {
		logic [PIX_W-1:0]   rgb_bits;
		logic [ROW_W-1:0]   row_address;
		logic               blank;
		logic [PLANE_W-1:0] bit_plane;
		logic               active_buffer;
		logic               row_end;
	} pix_word_t;

	typedef enum logic [2:0] {
		PH_PIXEL = 3'b001,
		PH_BLANK = 3'b010,
		PH_LATCH = 3'b100
	} phase_t;

endpackage

`default_nettype wire

FILE: hdl/lpss_cfg_regs.sv
// Configuration registers of the scan sequencer with range limiting.
`default_nettype none

module lpss_cfg_regs
	import lpss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	logic [HR_W-1:0]     half_rows_q;
	logic [LW_CFG_W-1:0] line_width_q;
	logic [PC_W-1:0]     plane_count_q;
	logic                jitter_enable_q;
	logic [CMP_W-1:0]    lw_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_rows_q     <= HR_W'(32);
			line_width_q    <= LW_CFG_W'(64);
			plane_count_q   <= PC_W'(8);
			jitter_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_HALF_ROWS:     half_rows_q     <= cfg_data[HR_W-1:0];
				CFG_LINE_WIDTH:    line_width_q    <= cfg_data[LW_CFG_W-1:0];
				CFG_PLANE_COUNT:   plane_count_q   <= cfg_data[PC_W-1:0];
				CFG_JITTER_ENABLE: jitter_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Zero counts as one, anything above the panel limit as the limit.
	assign lw_ext = CMP_W'(line_width_q);

	always_comb begin
		cfg.jitter_enable = jitter_enable_q;

		if (half_rows_q == '0)
			cfg.half_rows = HR_W'(1);
		else if (half_rows_q > HR_MAX)
			cfg.half_rows = HR_MAX;
		else
			cfg.half_rows = half_rows_q;

		if (lw_ext == '0)
			cfg.line_width = CMP_W'(1);
		else if (lw_ext > LW_MAX)
			cfg.line_width = LW_MAX;
		else
			cfg.line_width = lw_ext;

		if (plane_count_q == '0)
			cfg.plane_count = PC_W'(1);
		else if (plane_count_q > PC_MAX)
			cfg.plane_count = PC_MAX;
		else
			cfg.plane_count = plane_count_q;
	end

endmodule

`default_nettype wire

FILE: hdl/lpss_scan_ctrl.sv
// Scan position counters, buffer selection and the pixel stage register.
`default_nettype none

module lpss_scan_ctrl
	import lpss_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  wire logic in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	input  wire logic s1_done,
	output logic      s1_valid,
	output pix_word_t s1_word
);

	logic [COL_W-1:0]   column_count_q;
	logic [ROW_W-1:0]   row_count_q;
	logic [PLANE_W-1:0] plane_index_q;
	logic               shown_buffer_q;
	logic               seen_request_q;
	logic               s1_valid_q;
	pix_word_t          word_s1;

	logic               accept;
	logic [CMP_W-1:0]   col_inc;
	logic               row_end;
	logic               row_last;
	logic               plane_last;
	logic [HR_W-1:0]    hr_less_one;
	logic [ROW_W-1:0]   addr;
	pix_word_t          word_d;

	assign in_ready = !s1_valid_q || s1_done;
	assign accept   = in_valid && in_ready;

	assign col_inc    = CMP_W'(column_count_q) + CMP_W'(1);
	assign row_end    = col_inc >= cfg.line_width;
	assign row_last   = (HR_W'(row_count_q) + HR_W'(1)) >= cfg.half_rows;
	assign plane_last = (PC_W'(plane_index_q) + PC_W'(1)) >= cfg.plane_count;
	assign hr_less_one = cfg.half_rows - HR_W'(1);

	// The panel address trails the scan row by one, wrapping row zero to the top.
	always_comb begin
		if (row_count_q == '0)
			addr = hr_less_one[ROW_W-1:0];
		else
			addr = row_count_q - ROW_W'(1);
		addr = addr & ADDR_MASK;
	end

	always_comb begin
		word_d.rgb_bits      = in_item.pixel_bits;
		word_d.row_address   = addr;
		word_d.blank         = cfg.jitter_enable & in_item.oe_jitter;
		word_d.bit_plane     = plane_index_q;
		word_d.active_buffer = shown_buffer_q;
		word_d.row_end       = row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
			plane_index_q  <= '0;
			shown_buffer_q <= 1'b0;
			seen_request_q <= 1'b0;
			s1_valid_q     <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				if (!row_end) begin
					column_count_q <= col_inc[COL_W-1:0];
				end else begin
					column_count_q <= '0;
					if (row_last) begin
						row_count_q <= '0;
						if (in_item.buffer_request != seen_request_q) begin
							seen_request_q <= in_item.buffer_request;
							shown_buffer_q <= in_item.buffer_request;
						end
						if (plane_last)
							plane_index_q <= '0;
						else
							plane_index_q <= plane_index_q + PLANE_W'(1);
					end else begin
						row_count_q <= row_count_q + ROW_W'(1);
					end
				end
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			word_s1 <= word_d;
	end

	assign s1_valid = s1_valid_q;
	assign s1_word  = word_s1;

endmodule

`default_nettype wire

FILE: hdl/lpss_out_seq.sv
// Output sequencer: pixel, blanking and latch results into the output register.
`default_nettype none

module lpss_out_seq
	import lpss_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s1_valid,
	input  pix_word_t s1_word,
	output logic      s1_done,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_item
);

	phase_t    phase_q;
	phase_t    phase_d;
	logic      out_valid_q;
	out_item_t result_q;
	out_item_t result_d;
	logic      out_free;
	logic      emit;

	assign out_free = !out_valid_q || out_ready;
	assign emit     = s1_valid && out_free;

	always_comb begin
		result_d.rgb_bits      = '0;
		result_d.row_address   = '0;
		result_d.blank         = 1'b1;
		result_d.clock_rise    = 1'b0;
		result_d.latch         = 1'b0;
		result_d.bit_plane     = s1_word.bit_plane;
		result_d.active_buffer = s1_word.active_buffer;
		result_d.last          = 1'b0;
		phase_d                = phase_q;
		s1_done                = 1'b0;
		unique case (phase_q)
			PH_PIXEL: begin
				result_d.rgb_bits    = s1_word.rgb_bits;
				result_d.row_address = s1_word.row_address;
				result_d.blank       = s1_word.blank;
				result_d.clock_rise  = 1'b1;
				result_d.last        = !s1_word.row_end;
				phase_d              = s1_word.row_end ? PH_BLANK : PH_PIXEL;
				s1_done              = emit && !s1_word.row_end;
			end
			PH_BLANK: begin
				phase_d = PH_LATCH;
			end
			PH_LATCH: begin
				result_d.latch = 1'b1;
				result_d.last  = 1'b1;
				phase_d        = PH_PIXEL;
				s1_done        = emit;
			end
			default: begin
				phase_d = PH_PIXEL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PIXEL;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				phase_q     <= phase_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			result_q <= result_d;
	end

	assign out_valid = out_valid_q;
	assign out_item  = result_q;

endmodule

`default_nettype wire

FILE: hdl/led_panel_scan_sequencer_unit.sv
// Top level of the LED panel scan sequencer.
//
//   Channel   Handshake            Payload
//   in        in_valid/in_ready    in_item  (pixel word, jitter bit, buffer request)
//   out       out_valid/out_ready  out_item (pin word, address, strobes, plane, buffer)
//   cfg       cfg_we               cfg_index, cfg_data (no read-back)
//
// Each input item is one pixel of the scan order: bit plane, then row, then column.
// An item that does not end a row gives one result, so while out_ready is high the block
// takes an item every cycle. An item that ends a row gives three results (pixel, blanking
// word, latch); the output register accepts one result per cycle when it is free, so
// in_ready stays low until the latch result is accepted. The first result of an item
// passes through the pixel stage register and then the output register.
// Reset clears the scan counters, selects buffer A, loads the register defaults and
// empties both stages. When out_ready is low the output register holds and the
// pixel stage takes at most one more item before in_ready drops.
`default_nettype none

module led_panel_scan_sequencer_unit
	import lpss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  in_item_t                   in_item,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_item,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg;
	logic      s1_valid;
	logic      s1_done;
	pix_word_t s1_word;

	// Register file; values are limited to the panel's range before use.
	lpss_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Column, row and plane counters advance as each item is taken; the decoded
	// pixel waits in the stage register until its last result enters the output register.
	lpss_scan_ctrl u_scan_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.s1_done  (s1_done),
		.s1_valid (s1_valid),
		.s1_word  (s1_word)
	);

	// Steps through the pixel, blanking and latch results of the staged item.
	lpss_out_seq u_out_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1_word   (s1_word),
		.s1_done   (s1_done),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// A taken item always lands in the pixel stage.
	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> s1_valid)
		else $error("accepted item did not reach the pixel stage");

	// The pixel that ends a row is followed directly by the blanking word.
	a_blank_after_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.clock_rise && !out_item.last |=>
		out_valid && out_item.blank && !out_item.clock_rise && !out_item.latch)
		else $error("row end pixel not followed by blanking word");

	// A latch result drives all pins low with the display off and closes its item.
	a_latch_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.latch |->
		out_item.blank && out_item.last && (out_item.rgb_bits == '0) &&
		(out_item.row_address == '0) && !out_item.clock_rise)
		else $error("malformed latch result");

	// The stage does not take a new item while its current one is still being sent.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_done |-> !in_ready)
		else $error("input taken while pixel stage busy");

endmodule

`default_nettype wire
